>>> rtl/core/bwff_pkg.sv
// ----------------------------------------------------------------------------
// Blatt-Weisskopf form factor package
// Shared fixed-point types, constants and saturating helpers.
// ----------------------------------------------------------------------------
package bwff_pkg;

  typedef logic signed [63:0] q_t;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned DIV_STEPS     = 64;
  localparam int unsigned SQRT_STEPS    = 64;
  localparam int unsigned MASS_W        = 31;
  localparam int unsigned SPIN_W        = 3;
  localparam int unsigned CFG_DATA_W    = 31;
  localparam logic [30:0] RADIUS_RST    = 31'd25165824;

  localparam q_t SAT = 64'sh3FFF_FFFF_FFFF_FFFF;

  localparam logic [13:0] K2     = 14'd2;
  localparam logic [13:0] K9     = 14'd9;
  localparam logic [13:0] K13    = 14'd13;
  localparam logic [13:0] K15    = 14'd15;
  localparam logic [13:0] K21    = 14'd21;
  localparam logic [13:0] K25    = 14'd25;
  localparam logic [13:0] K45    = 14'd45;
  localparam logic [13:0] K105   = 14'd105;
  localparam logic [13:0] K277   = 14'd277;
  localparam logic [13:0] K12746 = 14'd12746;

  localparam logic [SPIN_W-1:0] SPIN_0 = 3'd0;
  localparam logic [SPIN_W-1:0] SPIN_1 = 3'd1;
  localparam logic [SPIN_W-1:0] SPIN_2 = 3'd2;
  localparam logic [SPIN_W-1:0] SPIN_3 = 3'd3;
  localparam logic [SPIN_W-1:0] SPIN_4 = 3'd4;

  typedef enum logic [1:0] {
    CFG_MASS_A = 2'd0,
    CFG_MASS_B = 2'd1,
    CFG_SPIN   = 2'd2,
    CFG_RADIUS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic v;
    logic below;
    logic zero;
    q_t   s;
    q_t   r2;
  } sb0_t;

  typedef struct packed {
    logic v;
    logic below;
    logic zero;
    q_t   r2;
  } sb1_t;

  typedef struct packed {
    logic v;
    logic below;
    logic zero;
  } sb2_t;

  typedef struct packed {
    logic v;
    logic below;
    q_t   z;
    q_t   k2;
    q_t   k9;
    q_t   k45;
    q_t   zp1;
  } sb3_t;

  typedef struct packed {
    logic v;
    logic below;
    q_t   z2;
    q_t   mb;
    q_t   mc;
    q_t   k2;
    q_t   k9;
    q_t   zp1;
  } sb4_t;

  typedef struct packed {
    logic v;
    logic below;
    logic bad;
  } sb5_t;

  typedef struct packed {
    logic v;
    logic below;
  } sb6_t;

  function automatic q_t sat_clamp(logic signed [64:0] v);
    q_t r;
    if (v > 65'(SAT)) begin
      r = SAT;
    end else if (v < -65'(SAT)) begin
      r = -SAT;
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic q_t sadd(q_t a, q_t b);
    return sat_clamp(65'(a) + 65'(b));
  endfunction

  function automatic q_t ssub(q_t a, q_t b);
    return sat_clamp(65'(a) - 65'(b));
  endfunction

  function automatic logic [63:0] smag(q_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic q_t smulk(q_t a, logic [13:0] k, logic [63:0] lim);
    logic [63:0] m;
    logic [77:0] p;
    m = smag(a);
    p = {14'd0, m} * {64'd0, k};
    if (m > lim) begin
      m = 64'(SAT);
    end else begin
      m = p[63:0];
    end
    return a[63] ? q_t'(-m) : q_t'(m);
  endfunction

endpackage

>>> rtl/core/bwff_if.sv
// ----------------------------------------------------------------------------
// Blatt-Weisskopf form factor channels
// Request and result streams with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bwff_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sqrt_s;

  modport source(output valid, output sqrt_s, input ready);
  modport sink(input valid, input sqrt_s, output ready);
endinterface

interface bwff_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] form_factor;
  logic        spin_invalid;
  logic        below_threshold;

  modport source(output valid, output form_factor, output spin_invalid,
                 output below_threshold, input ready);
  modport sink(input valid, input form_factor, input spin_invalid,
               input below_threshold, output ready);
endinterface

>>> rtl/core/bwff_delay.sv
// ----------------------------------------------------------------------------
// Sideband delay line
// Carries valid bits and side data alongside a pipelined unit.
// ----------------------------------------------------------------------------
module bwff_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe_q[i] <= '0;
      end
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

>>> rtl/core/bwff_mul.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point multiplier
// Three stages: partial products, sum, shift with saturation and sign.
// ----------------------------------------------------------------------------
module bwff_mul #(
  parameter int unsigned FRAC_BITS = bwff_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  bwff_pkg::q_t  a_i,
  input  bwff_pkg::q_t  b_i,
  output logic [127:0]  prod_o,
  output bwff_pkg::q_t  q_o
);

  import bwff_pkg::*;

  logic [63:0]  am, bm;
  logic [63:0]  p0_q, p1_q, p2_q, p3_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [127:0] sum_d, sum_q, prod_q;
  logic [127:0] shf;
  logic         ovf;
  logic [63:0]  mq;
  q_t           q_d, q_q;

  assign am = smag(a_i);
  assign bm = smag(b_i);

  assign sum_d = {64'd0, p0_q} + {32'd0, p1_q, 32'd0} + {32'd0, p2_q, 32'd0}
               + {p3_q, 64'd0};

  assign shf = sum_q >> FRAC_BITS;
  assign ovf = |(sum_q >> (62 + FRAC_BITS));
  assign mq  = ovf ? 64'(SAT) : shf[63:0];
  assign q_d = neg2_q ? q_t'(-mq) : q_t'(mq);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= am[31:0]  * bm[31:0];
      p1_q   <= am[31:0]  * bm[63:32];
      p2_q   <= am[63:32] * bm[31:0];
      p3_q   <= am[63:32] * bm[63:32];
      neg1_q <= a_i[63] ^ b_i[63];
      sum_q  <= sum_d;
      neg2_q <= neg1_q;
      prod_q <= sum_q;
      q_q    <= q_d;
      neg3_q <= neg2_q;
    end
  end

  assign prod_o = prod_q;
  assign q_o    = (neg3_q && (q_q == '0)) ? '0 : q_q;

endmodule

>>> rtl/core/bwff_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 128 by 64 bit unsigned division, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module bwff_div (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  hi_i,
  input  logic [63:0]  lo_i,
  input  logic [63:0]  d_i,
  output bwff_pkg::q_t q_o
);

  import bwff_pkg::*;

  logic [63:0] rem_q [DIV_STEPS+1];
  logic [63:0] lo_q  [DIV_STEPS+1];
  logic [63:0] d_q   [DIV_STEPS+1];
  logic [63:0] quo_q [DIV_STEPS+1];
  logic        sat_q [DIV_STEPS+1];
  q_t          q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi_i;
      lo_q[0]  <= lo_i;
      d_q[0]   <= d_i;
      quo_q[0] <= '0;
      sat_q[0] <= (hi_i >= d_i);
      q_q      <= (sat_q[DIV_STEPS] || (quo_q[DIV_STEPS] > 64'(SAT)))
                  ? SAT : q_t'(quo_q[DIV_STEPS]);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [64:0] sh;
    logic [64:0] dif;
    logic        ge;

    assign sh  = {rem_q[k], lo_q[k][63]};
    assign dif = sh - {1'b0, d_q[k]};
    assign ge  = (sh >= {1'b0, d_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? dif[63:0] : sh[63:0];
        lo_q[k+1]  <= {lo_q[k][62:0], 1'b0};
        d_q[k+1]   <= d_q[k];
        quo_q[k+1] <= {quo_q[k][62:0], ge};
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign q_o = q_q;

endmodule

>>> rtl/core/bwff_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of a 128 bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module bwff_sqrt (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [127:0] v_i,
  output logic [63:0]  root_o
);

  import bwff_pkg::*;

  logic [67:0]  rem_q  [SQRT_STEPS+1];
  logic [63:0]  root_q [SQRT_STEPS+1];
  logic [127:0] v_q    [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      v_q[0]    <= v_i;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [67:0] sh;
    logic [67:0] trial;
    logic        ge;

    assign sh    = {rem_q[k][65:0], v_q[k][127:126]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? (sh - trial) : sh;
        root_q[k+1] <= {root_q[k][62:0], ge};
        v_q[k+1]    <= {v_q[k][125:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQRT_STEPS];

endmodule

>>> rtl/core/blatt_weisskopf_form_factor_top.sv
// ----------------------------------------------------------------------------
// Blatt-Weisskopf form factor
// Barrier factor for spin 0 to 4 from an invariant mass, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one invariant mass sqrt_s (signed Q) per request.
//   res_o returns one result per request: form_factor (unsigned Q,
//   saturating), spin_invalid and below_threshold.
//   cfg_we_i/cfg_idx_i/cfg_data_i write daughter masses, spin and radius;
//   write them only while no request is in flight.
//   Throughput: one request per cycle while res_o is not stalled, fully pipelined.
//   A request passes through the two dividers, the root and four 3-stage
//   multiplier layers, plus the input, threshold and ratio registers.
//   Reset clears all valid bits and loads the register reset values.
//   A stall on res_o freezes the whole pipeline; req_i.ready drops in the
//   same cycle, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module blatt_weisskopf_form_factor_top #(
  parameter int unsigned FRAC_BITS = bwff_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [bwff_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  bwff_req_if.sink                          req_i,
  bwff_res_if.source                        res_o
);

  import bwff_pkg::*;

  localparam q_t Q1   = q_t'(64'd1 << FRAC_BITS);
  localparam q_t Q3   = q_t'(64'(K2 + 14'd1) << FRAC_BITS);
  localparam q_t Q5   = q_t'(64'(K2 + 14'd3) << FRAC_BITS);
  localparam q_t Q15  = q_t'(64'(K15) << FRAC_BITS);
  localparam q_t Q21  = q_t'(64'(K21) << FRAC_BITS);
  localparam q_t Q105 = q_t'(64'(K105) << FRAC_BITS);

  localparam logic [63:0] LIM2     = 64'(SAT) / 64'(K2);
  localparam logic [63:0] LIM9     = 64'(SAT) / 64'(K9);
  localparam logic [63:0] LIM13    = 64'(SAT) / 64'(K13);
  localparam logic [63:0] LIM25    = 64'(SAT) / 64'(K25);
  localparam logic [63:0] LIM45    = 64'(SAT) / 64'(K45);
  localparam logic [63:0] LIM277   = 64'(SAT) / 64'(K277);
  localparam logic [63:0] LIM12746 = 64'(SAT) / 64'(K12746);

  localparam logic [31:0] ONE32 = (FRAC_BITS >= 32) ? 32'hFFFF_FFFF
                                                    : 32'(64'd1 << FRAC_BITS);

  logic [MASS_W-1:0] mass_a_q, mass_b_q, radius_q;
  logic [SPIN_W-1:0] spin_q;
  cfg_idx_e          cfg_idx;
  logic              adv;

  // input stage
  logic [31:0] x;
  logic [31:0] msum;
  logic [30:0] mdif;
  logic        p1_v_q;
  logic [63:0] xx_q, ss_q, dd_q, rr_q;

  // threshold stage
  logic [63:0] s_d, ssh, ddh;
  q_t          t1, t2;
  sb0_t        sb0_d, sb0_q, sb0_o;
  logic [63:0] t1m_q, t2m_q;

  logic [127:0] m0_prod;
  q_t           q2;
  logic [63:0]  div0_d;
  sb1_t         sb1_d, sb1_o;
  q_t           m1_q;
  sb2_t         sb2_d, sb2_o;

  // z and linear terms
  logic pz_v_q, pz_below_q;
  q_t   z_q;
  q_t   k2_d, k9_d, k45_d, zp1_d, a3_d, a15_d, b5_d, b21_d, u_d;
  sb3_t sb3_d, sb3_q, sb3_o;
  q_t   u_q, w_q;

  q_t   l1_z2, l1_mb, l1_mc;

  sb4_t sb4_d, sb4_q, sb4_o;
  q_t   pa_z_q, pa_a4_q;

  q_t   l2_md, l2_me, l2_mf, l2_mg;

  // ratio terms
  q_t   num_d, da_d, db_d;
  q_t   num_q, da_q, db_q;
  logic pk_v_q, pk_below_q;

  q_t          den;
  logic [63:0] numc;
  sb5_t        sb5_d, sb5_q, sb5_o;
  logic [63:0] hi_q, lo_q, dv_q;

  q_t           q_ratio;
  q_t           r_sel;
  logic [127:0] root_in;
  logic [63:0]  root;
  sb6_t         sb6_d, sb6_o;

  logic        out_v_q;
  logic [31:0] form_q;
  logic        spin_inv_q, below_q;
  logic [31:0] form_d;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_a_q <= '0;
      mass_b_q <= '0;
      spin_q   <= SPIN_0;
      radius_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        CFG_MASS_A: mass_a_q <= cfg_data_i[MASS_W-1:0];
        CFG_MASS_B: mass_b_q <= cfg_data_i[MASS_W-1:0];
        CFG_SPIN:   spin_q   <= cfg_data_i[SPIN_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[MASS_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_v_q || res_o.ready;
  assign req_i.ready = adv;

  assign x    = req_i.sqrt_s[31] ? (~req_i.sqrt_s + 32'd1) : req_i.sqrt_s;
  assign msum = {1'b0, mass_a_q} + {1'b0, mass_b_q};
  assign mdif = (mass_a_q > mass_b_q) ? (mass_a_q - mass_b_q) : (mass_b_q - mass_a_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q <= x * x;
      ss_q <= msum * msum;
      dd_q <= 64'(mdif) * 64'(mdif);
      rr_q <= 64'(radius_q) * 64'(radius_q);
    end
  end

  assign s_d = xx_q >> FRAC_BITS;
  assign ssh = ss_q >> FRAC_BITS;
  assign ddh = dd_q >> FRAC_BITS;
  assign t1  = q_t'(s_d) - q_t'(ssh);
  assign t2  = q_t'(s_d) - q_t'(ddh);

  always_comb begin
    sb0_d       = '0;
    sb0_d.v     = p1_v_q;
    sb0_d.below = (t1 < 0 && t2 > 0) || (t1 > 0 && t2 < 0);
    sb0_d.zero  = (s_d == '0);
    sb0_d.s     = q_t'(s_d);
    sb0_d.r2    = q_t'(rr_q >> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      sb0_q  <= '0;
    end else if (adv) begin
      p1_v_q <= req_i.valid;
      sb0_q  <= sb0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1m_q <= smag(t1);
      t2m_q <= smag(t2);
    end
  end

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_q2 (
    .clk_i, .en_i(adv), .a_i(q_t'(t1m_q)), .b_i(q_t'(t2m_q)),
    .prod_o(m0_prod), .q_o()
  );

  bwff_delay #(.W($bits(sb0_t)), .DEPTH(3)) u_dly0 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb0_q), .q_o(sb0_o)
  );

  assign div0_d = sb0_o.zero ? 64'd1 : {sb0_o.s[61:0], 2'b00};

  bwff_div u_div_q2 (
    .clk_i, .en_i(adv), .hi_i(m0_prod[127:64]), .lo_i(m0_prod[63:0]),
    .d_i(div0_d), .q_o(q2)
  );

  always_comb begin
    sb1_d       = '0;
    sb1_d.v     = sb0_o.v;
    sb1_d.below = sb0_o.below;
    sb1_d.zero  = sb0_o.zero;
    sb1_d.r2    = sb0_o.r2;
  end

  bwff_delay #(.W($bits(sb1_t)), .DEPTH(DIV_STEPS + 2)) u_dly1 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb1_d), .q_o(sb1_o)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z (
    .clk_i, .en_i(adv), .a_i(q2), .b_i(sb1_o.r2), .prod_o(), .q_o(m1_q)
  );

  always_comb begin
    sb2_d       = '0;
    sb2_d.v     = sb1_o.v;
    sb2_d.below = sb1_o.below;
    sb2_d.zero  = sb1_o.zero;
  end

  bwff_delay #(.W($bits(sb2_t)), .DEPTH(3)) u_dly2 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb2_d), .q_o(sb2_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pz_v_q     <= 1'b0;
      pz_below_q <= 1'b0;
    end else if (adv) begin
      pz_v_q     <= sb2_o.v;
      pz_below_q <= sb2_o.below;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z_q <= sb2_o.zero ? SAT : m1_q;
    end
  end

  assign k2_d  = smulk(z_q, K2, LIM2);
  assign k9_d  = smulk(z_q, K9, LIM9);
  assign k45_d = smulk(z_q, K45, LIM45);
  assign zp1_d = sadd(z_q, Q1);
  assign a3_d  = ssub(z_q, Q3);
  assign a15_d = ssub(z_q, Q15);
  assign b5_d  = ssub(k2_d, Q5);
  assign b21_d = ssub(k2_d, Q21);

  always_comb begin
    case (spin_q)
      SPIN_2:  u_d = a3_d;
      SPIN_3:  u_d = a15_d;
      default: u_d = b21_d;
    endcase
  end

  always_comb begin
    sb3_d       = '0;
    sb3_d.v     = pz_v_q;
    sb3_d.below = pz_below_q;
    sb3_d.z     = z_q;
    sb3_d.k2    = k2_d;
    sb3_d.k9    = k9_d;
    sb3_d.k45   = k45_d;
    sb3_d.zp1   = zp1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb3_q <= '0;
    end else if (adv) begin
      sb3_q <= sb3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q <= u_d;
      w_q <= b5_d;
    end
  end

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z2 (
    .clk_i, .en_i(adv), .a_i(sb3_q.z), .b_i(sb3_q.z), .prod_o(), .q_o(l1_z2)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (
    .clk_i, .en_i(adv), .a_i(u_q), .b_i(u_q), .prod_o(), .q_o(l1_mb)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ww (
    .clk_i, .en_i(adv), .a_i(w_q), .b_i(w_q), .prod_o(), .q_o(l1_mc)
  );

  bwff_delay #(.W($bits(sb3_t)), .DEPTH(3)) u_dly3 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb3_q), .q_o(sb3_o)
  );

  always_comb begin
    sb4_d       = '0;
    sb4_d.v     = sb3_o.v;
    sb4_d.below = sb3_o.below;
    sb4_d.z2    = l1_z2;
    sb4_d.mb    = l1_mb;
    sb4_d.mc    = l1_mc;
    sb4_d.k2    = sb3_o.k2;
    sb4_d.k9    = sb3_o.k9;
    sb4_d.zp1   = sb3_o.zp1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb4_q <= '0;
    end else if (adv) begin
      sb4_q <= sb4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_z_q  <= sb3_o.z;
      pa_a4_q <= sadd(ssub(l1_z2, sb3_o.k45), Q105);
    end
  end

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z3 (
    .clk_i, .en_i(adv), .a_i(sb4_q.z2), .b_i(pa_z_q), .prod_o(), .q_o(l2_md)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_z4 (
    .clk_i, .en_i(adv), .a_i(sb4_q.z2), .b_i(sb4_q.z2), .prod_o(), .q_o(l2_me)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_zb (
    .clk_i, .en_i(adv), .a_i(pa_z_q), .b_i(sb4_q.mb), .prod_o(), .q_o(l2_mf)
  );

  bwff_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a4 (
    .clk_i, .en_i(adv), .a_i(pa_a4_q), .b_i(pa_a4_q), .prod_o(), .q_o(l2_mg)
  );

  bwff_delay #(.W($bits(sb4_t)), .DEPTH(3)) u_dly4 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb4_q), .q_o(sb4_o)
  );

  always_comb begin
    num_d = '0;
    da_d  = '0;
    db_d  = '0;
    case (spin_q)
      SPIN_1: begin
        num_d = sb4_o.k2;
        da_d  = sb4_o.zp1;
      end
      SPIN_2: begin
        num_d = smulk(sb4_o.z2, K13, LIM13);
        da_d  = sb4_o.mb;
        db_d  = sb4_o.k9;
      end
      SPIN_3: begin
        num_d = smulk(l2_md, K277, LIM277);
        da_d  = l2_mf;
        db_d  = smulk(sb4_o.mc, K9, LIM9);
      end
      SPIN_4: begin
        num_d = smulk(l2_me, K12746, LIM12746);
        da_d  = l2_mg;
        db_d  = smulk(l2_mf, K25, LIM25);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_v_q     <= 1'b0;
      pk_below_q <= 1'b0;
    end else if (adv) begin
      pk_v_q     <= sb4_o.v;
      pk_below_q <= sb4_o.below;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      da_q  <= da_d;
      db_q  <= db_d;
    end
  end

  assign den  = sadd(da_q, db_q);
  assign numc = num_q[63] ? 64'd0 : 64'(num_q);

  always_comb begin
    sb5_d       = '0;
    sb5_d.v     = pk_v_q;
    sb5_d.below = pk_below_q;
    sb5_d.bad   = (den <= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb5_q <= '0;
    end else if (adv) begin
      sb5_q <= sb5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hi_q <= numc >> (64 - FRAC_BITS);
      lo_q <= numc << FRAC_BITS;
      dv_q <= sb5_d.bad ? 64'd1 : 64'(den);
    end
  end

  bwff_div u_div_r (
    .clk_i, .en_i(adv), .hi_i(hi_q), .lo_i(lo_q), .d_i(dv_q), .q_o(q_ratio)
  );

  bwff_delay #(.W($bits(sb5_t)), .DEPTH(DIV_STEPS + 2)) u_dly5 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb5_q), .q_o(sb5_o)
  );

  assign r_sel   = sb5_o.bad ? SAT : q_ratio;
  assign root_in = 128'(r_sel) << FRAC_BITS;

  bwff_sqrt u_sqrt (
    .clk_i, .en_i(adv), .v_i(root_in), .root_o(root)
  );

  always_comb begin
    sb6_d       = '0;
    sb6_d.v     = sb5_o.v;
    sb6_d.below = sb5_o.below;
  end

  bwff_delay #(.W($bits(sb6_t)), .DEPTH(SQRT_STEPS + 1)) u_dly6 (
    .clk_i, .rst_ni, .en_i(adv), .d_i(sb6_d), .q_o(sb6_o)
  );

  always_comb begin
    if (spin_q == SPIN_0) begin
      form_d = ONE32;
    end else if (spin_q > SPIN_4) begin
      form_d = '0;
    end else if (|root[63:32]) begin
      form_d = 32'hFFFF_FFFF;
    end else begin
      form_d = root[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= sb6_o.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      form_q     <= form_d;
      spin_inv_q <= (spin_q > SPIN_4);
      below_q    <= sb6_o.below;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.form_factor     = form_q;
  assign res_o.spin_invalid    = spin_inv_q;
  assign res_o.below_threshold = below_q;

endmodule

>>> rtl/core/bwff_checker.sv
// ----------------------------------------------------------------------------
// Blatt-Weisskopf form factor checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module bwff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] form_factor_i,
  input logic        spin_invalid_i,
  input logic        below_threshold_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(form_factor_i) && $stable(spin_invalid_i)
      && $stable(below_threshold_i))
    else $error("result changed while stalled");

  a_bad_spin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && spin_invalid_i |-> form_factor_i == 32'd0)
    else $error("invalid spin with nonzero factor");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_i == (!res_valid_i || res_ready_i))
    else $error("request ready does not follow pipeline advance");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !res_valid_i && !req_valid_i || !res_valid_i)
    else $error("result right after reset");

endmodule

bind blatt_weisskopf_form_factor_top bwff_checker u_bwff_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .form_factor_i     (res_o.form_factor),
  .spin_invalid_i    (res_o.spin_invalid),
  .below_threshold_i (res_o.below_threshold)
);
